[sv/pwag_pkg.sv]
// pwag_pkg: shared constants, config register indexes and the quarter-wave sine table
// for the polar warp address generator. No dependencies.
`default_nettype none

package pwag_pkg;

  localparam int ROW_W     = 12;
  localparam int COL_W     = 12;
  localparam int COLOR_W   = 32;
  localparam int OUT_W     = 12;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int R8_SHIFT  = 7;
  localparam int R8_W      = ROW_W + R8_SHIFT;
  localparam int TBL_BITS  = 10;
  localparam int SIN_W     = 16;
  localparam int QWV_W     = 15;
  localparam int POS_SHIFT = 23;
  localparam int W_RESET   = 640;
  localparam int H_RESET   = 480;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [TBL_BITS-1:0] TBL_QUARTER = 10'd256;
  localparam logic [63:0]         PI_Q30      = 64'd3373259426;

  typedef logic [QWV_W-1:0] qwave_t [0:256];

  // sin(k*pi/512), Taylor series to the 13th order in Q30, rounded to Q1.15
  function automatic qwave_t build_qwave();
    qwave_t      tbl;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    for (int k = 0; k <= 256; k++) begin
      x    = (64'(k) * PI_Q30) >> 9;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + term;
      v    = (sum * 64'd32768 + (64'd1 << 29)) >> 30;
      tbl[k] = (v > 64'd32767) ? 15'h7fff : v[QWV_W-1:0];
    end
    return tbl;
  endfunction

  localparam qwave_t QWAVE = build_qwave();

  function automatic logic signed [SIN_W-1:0] sine_val(input logic [TBL_BITS-1:0] addr);
    logic [8:0]       idx;
    logic [QWV_W-1:0] mag;
    idx = addr[8] ? (9'd256 - {1'b0, addr[7:0]}) : {1'b0, addr[7:0]};
    mag = QWAVE[idx];
    return addr[9] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

`default_nettype wire

[sv/pwag_div_step.sv]
// pwag_div_step: one registered stage of the two restoring dividers (radius and phase),
// one quotient bit each, with valid and color carried alongside. Uses pwag_pkg.
`default_nettype none

module pwag_div_step import pwag_pkg::*; #(
  parameter int DEN_W = 13,
  parameter int QUO_W = 28
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               v_i,
  input  wire logic [DEN_W-1:0]   den_r8_i,
  input  wire logic [DEN_W-1:0]   den_ph_i,
  input  wire logic [DEN_W-1:0]   rem_r8_i,
  input  wire logic [QUO_W-1:0]   nq_r8_i,
  input  wire logic [DEN_W-1:0]   rem_ph_i,
  input  wire logic [QUO_W-1:0]   nq_ph_i,
  input  wire logic [COLOR_W-1:0] color_i,
  output logic                    v_o,
  output logic [DEN_W-1:0]        rem_r8_o,
  output logic [QUO_W-1:0]        nq_r8_o,
  output logic [DEN_W-1:0]        rem_ph_o,
  output logic [QUO_W-1:0]        nq_ph_o,
  output logic [COLOR_W-1:0]      color_o
);

  logic               v_r;
  logic [DEN_W-1:0]   rem_r8_r;
  logic [QUO_W-1:0]   nq_r8_r;
  logic [DEN_W-1:0]   rem_ph_r;
  logic [QUO_W-1:0]   nq_ph_r;
  logic [COLOR_W-1:0] color_r;

  logic [DEN_W:0]   t_r8;
  logic [DEN_W:0]   t_ph;
  logic [DEN_W:0]   diff_r8;
  logic [DEN_W:0]   diff_ph;
  logic             ge_r8;
  logic             ge_ph;
  logic [DEN_W-1:0] rem_r8_nxt;
  logic [DEN_W-1:0] rem_ph_nxt;

  always_comb begin
    t_r8       = {rem_r8_i, nq_r8_i[QUO_W-1]};
    t_ph       = {rem_ph_i, nq_ph_i[QUO_W-1]};
    diff_r8    = t_r8 - {1'b0, den_r8_i};
    diff_ph    = t_ph - {1'b0, den_ph_i};
    ge_r8      = (t_r8 >= {1'b0, den_r8_i});
    ge_ph      = (t_ph >= {1'b0, den_ph_i});
    rem_r8_nxt = ge_r8 ? diff_r8[DEN_W-1:0] : t_r8[DEN_W-1:0];
    rem_ph_nxt = ge_ph ? diff_ph[DEN_W-1:0] : t_ph[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r8_r <= rem_r8_nxt;
      nq_r8_r  <= {nq_r8_i[QUO_W-2:0], ge_r8};
      rem_ph_r <= rem_ph_nxt;
      nq_ph_r  <= {nq_ph_i[QUO_W-2:0], ge_ph};
      color_r  <= color_i;
    end
  end

  assign v_o      = v_r;
  assign rem_r8_o = rem_r8_r;
  assign nq_r8_o  = nq_r8_r;
  assign rem_ph_o = rem_ph_r;
  assign nq_ph_o  = nq_ph_r;
  assign color_o  = color_r;

endmodule

`default_nettype wire

[sv/pwag_place.sv]
// pwag_place: four-stage back end: phase to sine/cosine lookup, radius multiply,
// center offset add, clamp to the frame. Uses pwag_pkg (sine table, widths).
`default_nettype none

module pwag_place import pwag_pkg::*; #(
  parameter int DIM_W      = 13,
  parameter int PHASE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire logic                  v_i,
  input  wire logic [R8_W-1:0]       r8_i,
  input  wire logic [PHASE_BITS-1:0] ph_i,
  input  wire logic [COLOR_W-1:0]    color_i,
  input  wire logic [DIM_W-1:0]      w_i,
  input  wire logic [DIM_W-1:0]      h_i,
  output logic                       v_o,
  output logic [OUT_W-1:0]           x_o,
  output logic [OUT_W-1:0]           y_o,
  output logic [COLOR_W-1:0]         color_o
);

  localparam int PROD_W = R8_W + 1 + SIN_W;
  localparam int PW     = ((DIM_W + POS_SHIFT - 1 > PROD_W) ?
                           (DIM_W + POS_SHIFT - 1) : PROD_W) + 2;
  localparam int D_W    = PW - POS_SHIFT - 1;
  localparam logic [PHASE_BITS-1:0] PH_QUARTER = {2'b01, {(PHASE_BITS-2){1'b0}}};

  logic [PHASE_BITS-1:0] phase;
  logic [TBL_BITS-1:0]   addr_s;
  logic [TBL_BITS-1:0]   addr_c;

  logic                     v1_r;
  logic [R8_W-1:0]          r8_1_r;
  logic signed [SIN_W-1:0]  sin_1_r;
  logic signed [SIN_W-1:0]  cos_1_r;
  logic [COLOR_W-1:0]       color_1_r;

  logic                     v2_r;
  logic signed [PROD_W-1:0] px_2_r;
  logic signed [PROD_W-1:0] py_2_r;
  logic [COLOR_W-1:0]       color_2_r;

  logic                     v3_r;
  logic signed [PW-1:0]     posx_3_r;
  logic signed [PW-1:0]     posy_3_r;
  logic [COLOR_W-1:0]       color_3_r;

  logic                     v4_r;
  logic [OUT_W-1:0]         x4_r;
  logic [OUT_W-1:0]         y4_r;
  logic [COLOR_W-1:0]       color_4_r;

  function automatic logic signed [PW-1:0] center(input logic [DIM_W-1:0] dim);
    return $signed(PW'({dim, {(POS_SHIFT-1){1'b0}}}));
  endfunction

  function automatic logic [OUT_W-1:0] clamp_pos(input logic signed [PW-1:0] pos,
                                                 input logic [DIM_W-1:0]     dim);
    logic [D_W-1:0] d;
    logic [D_W-1:0] lim;
    d   = pos[PW-2:POS_SHIFT];
    lim = {{(D_W-DIM_W){1'b0}}, dim - DIM_W'(1)};
    if (pos[PW-1]) begin
      return '0;
    end else if (d > lim) begin
      return lim[OUT_W-1:0];
    end else begin
      return d[OUT_W-1:0];
    end
  endfunction

  // rotate by -pi/2, then take the top table bits (zero-padded if the phase is narrower)
  assign phase = ph_i - PH_QUARTER;

  generate
    if (PHASE_BITS >= TBL_BITS) begin : g_addr_hi
      assign addr_s = phase[PHASE_BITS-1 -: TBL_BITS];
    end else begin : g_addr_lo
      assign addr_s = {phase, {(TBL_BITS-PHASE_BITS){1'b0}}};
    end
  endgenerate

  assign addr_c = addr_s + TBL_QUARTER;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r8_1_r    <= r8_i;
      sin_1_r   <= sine_val(addr_s);
      cos_1_r   <= sine_val(addr_c);
      color_1_r <= color_i;

      px_2_r    <= $signed({1'b0, r8_1_r}) * cos_1_r;
      py_2_r    <= $signed({1'b0, r8_1_r}) * sin_1_r;
      color_2_r <= color_1_r;

      posx_3_r  <= center(w_i) + PW'(px_2_r);
      posy_3_r  <= center(h_i) + PW'(py_2_r);
      color_3_r <= color_2_r;

      x4_r      <= clamp_pos(posx_3_r, w_i);
      y4_r      <= clamp_pos(posy_3_r, h_i);
      color_4_r <= color_3_r;
    end
  end

  assign v_o     = v4_r;
  assign x_o     = x4_r;
  assign y_o     = y4_r;
  assign color_o = color_4_r;

endmodule

`default_nettype wire

[sv/polar_warp_address_generator.sv]
// polar_warp_address_generator: top level. Config registers, input and multiply stages,
// divider chain (pwag_div_step), back end (pwag_place), output register with skid stage.
//
//   channel  direction  handshake             payload
//   in       request    in_valid / in_stall   in_src_row, in_src_col, in_pixel_color
//   out      result     out_valid / out_stall out_dest_x, out_dest_y, out_color
//   cfg      write      cfg_we                cfg_index, cfg_wdata
//
// One request per cycle sustained while in_stall is low. The two restoring dividers run
// PHASE_BITS + 12 stages of one quotient bit each. Synchronous active-low reset clears
// valids and the skid stage and sets the config registers to 640 x 480. in_stall rises
// only when the skid stage is full; the whole pipeline then holds until out_stall drops.
`default_nettype none

module polar_warp_address_generator import pwag_pkg::*; #(
  parameter int MAX_DIM    = 4096,
  parameter int PHASE_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [ROW_W-1:0]     in_src_row,
  input  wire logic [COL_W-1:0]     in_src_col,
  input  wire logic [COLOR_W-1:0]   in_pixel_color,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [OUT_W-1:0]          out_dest_x,
  output logic [OUT_W-1:0]          out_dest_y,
  output logic [COLOR_W-1:0]        out_color
);

  localparam int DIM_CAP = (MAX_DIM < (1 << CFG_W) - 1) ? MAX_DIM : (1 << CFG_W) - 1;
  localparam int DIM_W   = $clog2(DIM_CAP + 1);
  localparam int QW      = COL_W + PHASE_BITS;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (int'(v) > DIM_CAP) begin
      return DIM_W'(DIM_CAP);
    end else begin
      return v[DIM_W-1:0];
    end
  endfunction

  logic [DIM_W-1:0] w_eff_r;
  logic [DIM_W-1:0] h_eff_r;
  logic [DIM_W-1:0] m_dim;
  logic             adv;

  logic               va_r;
  logic [ROW_W-1:0]   row_a_r;
  logic [COL_W-1:0]   col_a_r;
  logic [COLOR_W-1:0] color_a_r;

  logic                   vb_r;
  logic [DIM_W+ROW_W-1:0] prod_b_r;
  logic [COL_W-1:0]       col_b_r;
  logic [COLOR_W-1:0]     color_b_r;
  logic [DIM_W+QW-1:0]    n1_ext;

  logic               v_c      [QW+1];
  logic [DIM_W-1:0]   rem_r8_c [QW+1];
  logic [QW-1:0]      nq_r8_c  [QW+1];
  logic [DIM_W-1:0]   rem_ph_c [QW+1];
  logic [QW-1:0]      nq_ph_c  [QW+1];
  logic [COLOR_W-1:0] color_c  [QW+1];

  logic [R8_W-1:0]       r8_q;
  logic [PHASE_BITS-1:0] ph_q;

  logic               pl_v;
  logic [OUT_W-1:0]   pl_x;
  logic [OUT_W-1:0]   pl_y;
  logic [COLOR_W-1:0] pl_color;

  logic               out_valid_r;
  logic [OUT_W-1:0]   out_x_r;
  logic [OUT_W-1:0]   out_y_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               skid_full_r;
  logic [OUT_W-1:0]   skid_x_r;
  logic [OUT_W-1:0]   skid_y_r;
  logic [COLOR_W-1:0] skid_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= eff_dim(CFG_W'(W_RESET));
      h_eff_r <= eff_dim(CFG_W'(H_RESET));
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  w_eff_r <= eff_dim(cfg_wdata);
        CFG_IMAGE_HEIGHT: h_eff_r <= eff_dim(cfg_wdata);
        default:          w_eff_r <= w_eff_r;
      endcase
    end
  end

  assign m_dim    = (w_eff_r < h_eff_r) ? w_eff_r : h_eff_r;
  assign adv      = !skid_full_r;
  assign in_stall = skid_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row_a_r   <= in_src_row;
      col_a_r   <= in_src_col;
      color_a_r <= in_pixel_color;
      prod_b_r  <= {{ROW_W{1'b0}}, m_dim} * {{DIM_W{1'b0}}, row_a_r};
      col_b_r   <= col_a_r;
      color_b_r <= color_a_r;
    end
  end

  // radius numerator min*row*128 over height; phase numerator col*2^PHASE_BITS over width
  assign n1_ext      = {{(QW-R8_W){1'b0}}, prod_b_r, {R8_SHIFT{1'b0}}};
  assign v_c[0]      = vb_r;
  assign rem_r8_c[0] = n1_ext[DIM_W+QW-1:QW];
  assign nq_r8_c[0]  = n1_ext[QW-1:0];
  assign rem_ph_c[0] = '0;
  assign nq_ph_c[0]  = {col_b_r, {PHASE_BITS{1'b0}}};
  assign color_c[0]  = color_b_r;

  generate
    for (genvar g = 0; g < QW; g++) begin : g_div
      pwag_div_step #(
        .DEN_W (DIM_W),
        .QUO_W (QW)
      ) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .v_i      (v_c[g]),
        .den_r8_i (h_eff_r),
        .den_ph_i (w_eff_r),
        .rem_r8_i (rem_r8_c[g]),
        .nq_r8_i  (nq_r8_c[g]),
        .rem_ph_i (rem_ph_c[g]),
        .nq_ph_i  (nq_ph_c[g]),
        .color_i  (color_c[g]),
        .v_o      (v_c[g+1]),
        .rem_r8_o (rem_r8_c[g+1]),
        .nq_r8_o  (nq_r8_c[g+1]),
        .rem_ph_o (rem_ph_c[g+1]),
        .nq_ph_o  (nq_ph_c[g+1]),
        .color_o  (color_c[g+1])
      );
    end
  endgenerate

  assign r8_q = nq_r8_c[QW][R8_W-1:0];
  assign ph_q = nq_ph_c[QW][PHASE_BITS-1:0];

  pwag_place #(
    .DIM_W      (DIM_W),
    .PHASE_BITS (PHASE_BITS)
  ) u_place (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .v_i     (v_c[QW]),
    .r8_i    (r8_q),
    .ph_i    (ph_q),
    .color_i (color_c[QW]),
    .w_i     (w_eff_r),
    .h_i     (h_eff_r),
    .v_o     (pl_v),
    .x_o     (pl_x),
    .y_o     (pl_y),
    .color_o (pl_color)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (!out_stall) begin
        out_x_r     <= skid_x_r;
        out_y_r     <= skid_y_r;
        out_color_r <= skid_color_r;
        skid_full_r <= 1'b0;
      end
    end else if (pl_v) begin
      if (!out_valid_r || !out_stall) begin
        out_x_r     <= pl_x;
        out_y_r     <= pl_y;
        out_color_r <= pl_color;
        out_valid_r <= 1'b1;
      end else begin
        skid_x_r     <= pl_x;
        skid_y_r     <= pl_y;
        skid_color_r <= pl_color;
        skid_full_r  <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_dest_x = out_x_r;
  assign out_dest_y = out_y_r;
  assign out_color  = out_color_r;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid stage full while output register empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_full_r && out_stall) |=> skid_full_r)
    else $error("skid stage drained while output stalled");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pl_v && !skid_full_r))
    else $error("output went valid without a pipeline result");

  a_dims_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (w_eff_r != '0) && (h_eff_r != '0))
    else $error("effective frame dimension is zero");
`endif

endmodule

`default_nettype wire
